FILE: rtl/core/slt_pkg.sv
// ----------------------------------------------------------------------------
// slt_pkg
// types, keyword table and constants shared by the source line tokenizer
// ----------------------------------------------------------------------------
package slt_pkg;

  localparam int unsigned LINE_LENGTH_DEF = 256;
  localparam int unsigned NUM_KW          = 10;
  localparam int unsigned KW_MAX_LEN      = 6;
  localparam int unsigned FIFO_DEPTH      = 4;
  localparam logic [7:0]  LEN_MAX         = 8'd255;
  localparam logic [NUM_KW-1:0] KW_ALL    = '1;

  typedef enum logic [2:0] {
    KIND_OP    = 3'd0,
    KIND_KW    = 3'd1,
    KIND_INT   = 3'd2,
    KIND_IDENT = 3'd3,
    KIND_UNID  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] op_char;
    logic [3:0] keyword_id;
    logic [7:0] start_col;
    logic [7:0] tok_len;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  w0;
    out_word_t  w1;
  } push_t;

  // keyword text, first character in element 0, zero padded
  localparam logic [0:KW_MAX_LEN-1][7:0] KW_TEXT [NUM_KW] = '{
    {"if",     32'd0},
    {"else",   16'd0},
    {"elif",   16'd0},
    {"while",   8'd0},
    {"return"       },
    {"int",    24'd0},
    {"var",    24'd0},
    {"for",    24'd0},
    {"long",   16'd0},
    {"short",   8'd0}
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd2, 3'd4, 3'd4, 3'd5, 3'd6, 3'd3, 3'd3, 3'd3, 3'd4, 3'd5
  };

endpackage

FILE: rtl/core/slt_lexer.sv
// ----------------------------------------------------------------------------
// slt_lexer
// word state and per-character classification, up to two tokens per character
// ----------------------------------------------------------------------------
module slt_lexer import slt_pkg::*; #(
  parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     proc_i,
  input  in_word_t word_i,
  output push_t    push_o
);

  localparam logic [7:0] COL_MAX = (LINE_LENGTH - 1 < 255) ? 8'(LINE_LENGTH - 1) : 8'd255;

  logic [7:0]        column_q, column_d;
  logic [7:0]        word_start_q, word_start_d;
  logic [7:0]        word_length_q, word_length_d;
  logic              all_digits_q, all_digits_d;
  logic              first_digit_q, first_digit_d;
  logic [NUM_KW-1:0] alive_q, alive_d;

  logic              is_op, delim, digit, start_new, close;
  logic [7:0]        ws_n, wl_n;
  logic              ad_n, fd_n;
  logic [NUM_KW-1:0] alive_n, ok;
  logic              match;
  logic [3:0]        match_id;
  kind_e             word_kind;
  out_word_t         word_tok, op_tok;

  always_comb begin
    is_op = word_i.ch inside {"+", "-", "*", "/", ">", "<", "=", "%"};
    delim = is_op || (word_i.ch inside {" ", ",", ";", "(", ")", "[", "]", "{", "}"});
    digit = word_i.ch inside {["0":"9"]};
    start_new = !delim && (word_length_q == 8'd0);

    for (int k = 0; k < NUM_KW; k++) begin
      ok[k] = (word_length_q < {5'd0, KW_LEN[k]}) &&
              (KW_TEXT[k][word_length_q[2:0]] == word_i.ch);
    end

    ws_n    = start_new ? column_q : word_start_q;
    fd_n    = start_new ? digit : first_digit_q;
    ad_n    = start_new ? 1'b1 : all_digits_q;
    alive_n = start_new ? KW_ALL : alive_q;
    wl_n    = word_length_q;
    if (!delim) begin
      alive_n = alive_n & ok;
      ad_n    = ad_n & digit;
      if (word_length_q < LEN_MAX) begin
        wl_n = word_length_q + 8'd1;
      end
    end

    close = (delim || word_i.line_end) && (wl_n != 8'd0);

    match    = 1'b0;
    match_id = 4'd0;
    for (int k = NUM_KW - 1; k >= 0; k--) begin
      if (alive_n[k] && (wl_n == {5'd0, KW_LEN[k]})) begin
        match    = 1'b1;
        match_id = 4'(k);
      end
    end

    if (match) begin
      word_kind = KIND_KW;
    end else if (ad_n) begin
      word_kind = KIND_INT;
    end else if (!fd_n) begin
      word_kind = KIND_IDENT;
    end else begin
      word_kind = KIND_UNID;
    end

    word_tok.kind       = word_kind;
    word_tok.op_char    = 8'd0;
    word_tok.keyword_id = match ? match_id : 4'd0;
    word_tok.start_col  = ws_n;
    word_tok.tok_len    = wl_n;
    word_tok.last       = !is_op;

    op_tok.kind       = KIND_OP;
    op_tok.op_char    = word_i.ch;
    op_tok.keyword_id = 4'd0;
    op_tok.start_col  = column_q;
    op_tok.tok_len    = 8'd1;
    op_tok.last       = 1'b1;

    if (close) begin
      push_o.w0    = word_tok;
      push_o.w1    = op_tok;
      push_o.count = is_op ? 2'd2 : 2'd1;
    end else begin
      push_o.w0    = op_tok;
      push_o.w1    = op_tok;
      push_o.count = is_op ? 2'd1 : 2'd0;
    end
    if (!proc_i) begin
      push_o.count = 2'd0;
    end

    // next word state
    word_start_d  = ws_n;
    word_length_d = wl_n;
    all_digits_d  = ad_n;
    first_digit_d = fd_n;
    alive_d       = alive_n;
    if (close || word_i.line_end) begin
      word_length_d = 8'd0;
      all_digits_d  = 1'b1;
      first_digit_d = 1'b0;
      alive_d       = KW_ALL;
    end

    if (word_i.line_end) begin
      column_d = 8'd0;
    end else if (column_q < COL_MAX) begin
      column_d = column_q + 8'd1;
    end else begin
      column_d = column_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q      <= 8'd0;
      word_start_q  <= 8'd0;
      word_length_q <= 8'd0;
      all_digits_q  <= 1'b1;
      first_digit_q <= 1'b0;
      alive_q       <= KW_ALL;
    end else if (proc_i) begin
      column_q      <= column_d;
      word_start_q  <= word_start_d;
      word_length_q <= word_length_d;
      all_digits_q  <= all_digits_d;
      first_digit_q <= first_digit_d;
      alive_q       <= alive_d;
    end
  end

`ifndef SYNTHESIS
  a_no_word_keeps_alive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (word_length_q == 8'd0) |-> (alive_q == KW_ALL && all_digits_q))
    else $error("idle word state not cleared");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_o.count == 2'd2) |-> (!push_o.w0.last && push_o.w1.last &&
                                push_o.w1.kind == KIND_OP))
    else $error("token pair out of order");
  a_column_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    column_q <= COL_MAX)
    else $error("column past limit");
`endif

endmodule

FILE: rtl/core/slt_out_fifo.sv
// ----------------------------------------------------------------------------
// slt_out_fifo
// four-entry queue, takes up to two tokens, gives one per cycle unless stalled
// ----------------------------------------------------------------------------
module slt_out_fifo import slt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      space_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  localparam int unsigned PW = $clog2(FIFO_DEPTH);
  localparam int unsigned CW = $clog2(FIFO_DEPTH + 1);

  out_word_t         mem_q [FIFO_DEPTH];
  logic [PW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic              pop;

  assign pop         = out_valid_o && !out_stall_i;
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = mem_q[rd_ptr_q];
  assign space_o     = (count_q <= CW'(FIFO_DEPTH - 2));

  always_comb begin
    wr_ptr_d = wr_ptr_q + PW'(push_i.count);
    rd_ptr_d = pop ? rd_ptr_q + PW'(1) : rd_ptr_q;
    count_d  = count_q + CW'(push_i.count) - (pop ? CW'(1) : CW'(0));
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.w0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_q + PW'(1)] <= push_i.w1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FIFO_DEPTH))
    else $error("token queue overflow");
  a_push_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.count != 2'd0) |-> (count_q <= CW'(FIFO_DEPTH - 2)))
    else $error("push without room");
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == count_q[PW-1:0])
    else $error("queue pointers and count disagree");
`endif

endmodule

FILE: rtl/core/source_line_tokenizer.sv
// ----------------------------------------------------------------------------
// source_line_tokenizer
// byte-per-cycle lexer that turns a source line into keyword, integer,
// identifier, unidentified and operator tokens
// ----------------------------------------------------------------------------
// usage
//   in channel: one character word per handshake (in_valid_i high, in_stall_o
//   low), line_end marks the last character of a line
//   out channel: one token word per handshake (out_valid_o high, out_stall_i
//   low); last marks the final token caused by one character
//   path: a taken character is registered, then classified and written into
//   the token queue, from which its tokens are offered in order
//   throughput: one character per cycle while in_stall_o is low; a delimiter
//   that closes a word and is an operator gives two tokens, and the output
//   side drains one token per cycle while out_stall_i is low, which sets the
//   long-run rate; the four-entry queue takes bursts
//   stall: when the receiver stalls, tokens collect in the queue; once fewer
//   than two entries are free the input register holds and in_stall_o rises
//   reset: column at zero, no open word, token queue empty, no clearing pass
// ----------------------------------------------------------------------------
module source_line_tokenizer import slt_pkg::*; #(
  parameter int unsigned LINE_LENGTH = LINE_LENGTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_word_t  in_word_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_word_t out_word_o
);

  logic     in_valid_q;
  in_word_t in_word_q;
  logic     space;
  logic     proc;
  push_t    push;

  assign proc       = in_valid_q && space;
  assign in_stall_o = in_valid_q && !space;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_word_q <= in_word_i;
    end
  end

  slt_lexer #(
    .LINE_LENGTH (LINE_LENGTH)
  ) u_lexer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .proc_i (proc),
    .word_i (in_word_q),
    .push_o (push)
  );

  slt_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
